// ===== design/ddg_pkg.sv =====
// Package for the disc density grid: field widths, register and item codes,
// and the payload types of the input and result channels.
// No dependencies.
package ddg_pkg;

  // Field widths
  localparam int POS_W     = 14;
  localparam int RAD_W     = 12;
  localparam int MEAN_W    = 24;
  localparam int HIT_W     = 13;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Saturation limits of the result fields
  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};
  localparam logic [HIT_W-1:0]  HIT_MAX  = {HIT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;

  // Item kinds
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Reset value of both grid size registers
  localparam logic [CFG_W-1:0] CELLS_RESET = 7'd64;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [RAD_W-1:0] disc_radius;
  } disc_in_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_density;
    logic [HIT_W-1:0]  cells_hit;
    logic              empty_disc;
  } disc_out_t;

endpackage

// ===== design/ddg_chan_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; used with the types of ddg_pkg.
interface ddg_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/disc_density_grid.sv =====
// Disc density grid: counter grid in one synchronous RAM, box scanner,
// distance pipeline with read-modify-write, and a serial divider for the mean.
// Depends on ddg_pkg and ddg_chan_if.
//
//   port     | dir | payload                                   | item
//   in_ch    | in  | kind, pos_x, pos_y, disc_radius           | one disc
//   out_ch   | out | mean_density, cells_hit, empty_disc       | one result
//   cfg_*    | in  | cfg_index, cfg_data (write only)          | one register
//
// The scan covers W*H cells, where W*H is the clamped bounding box
// (up to 33x33 at full radius). A sample item with hits adds
// COUNT_WIDTH + clog2(grid depth + 1) + FRAC_BITS divider steps.
// The scan walks one cell a cycle through a single RAM read port and write port.
// After reset a clearing pass zeroes every cell of the RAM;
// no item is taken meanwhile. One item is in work at a time; the result
// register lets the next item enter while the last result waits.
module disc_density_grid #(
  parameter int MAX_CELLS_X = 64,
  parameter int MAX_CELLS_Y = 64,
  parameter int FRAC_BITS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  ddg_chan_if.sink                       in_ch,
  ddg_chan_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ddg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddg_pkg::CFG_W-1:0]      cfg_data
);
  import ddg_pkg::*;

  localparam int DEPTH = MAX_CELLS_X * MAX_CELLS_Y;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NXW   = $clog2(MAX_CELLS_X + 1);
  localparam int NYW   = $clog2(MAX_CELLS_Y + 1);
  localparam int CXW   = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
  localparam int CYW   = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
  localparam int BW    = POS_W + 1;
  localparam int DW    = POS_W + 3;
  localparam int SQW   = 2 * DW;
  localparam int R2W   = 2 * RAD_W;
  localparam int HW    = $clog2(DEPTH + 1);
  localparam int SW    = COUNT_WIDTH + HW;
  localparam int NW    = SW + FRAC_BITS;
  localparam int RW    = HW + 1;
  localparam int CNTW  = $clog2(NW + 1);
  localparam int QW    = (NW > MEAN_W) ? NW : MEAN_W;
  localparam logic [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_BOX   = 8'b0000_0100,
    ST_BASE  = 8'b0000_1000,
    ST_SCAN  = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers and effective grid size
  logic [CFG_W-1:0] cells_x, cells_y;
  logic [NXW-1:0]   nx;
  logic [NYW-1:0]   ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= CELLS_RESET;
      cells_y <= CELLS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_CELLS_X) cells_x <= cfg_data;
      if (cfg_index == REG_CELLS_Y) cells_y <= cfg_data;
    end
  end

  always_comb begin
    if (cells_x == '0)                    nx = NXW'(1);
    else if (int'(cells_x) > MAX_CELLS_X) nx = NXW'(MAX_CELLS_X);
    else                                  nx = NXW'(cells_x);
    if (cells_y == '0)                    ny = NYW'(1);
    else if (int'(cells_y) > MAX_CELLS_Y) ny = NYW'(MAX_CELLS_Y);
    else                                  ny = NYW'(cells_y);
  end

  // Captured item
  logic             kind_q;
  logic [POS_W-1:0] px_q, py_q;
  logic [RAD_W-1:0] rad_q;
  logic [R2W-1:0]   r2;

  // Bounding box
  logic [BW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [BW-1:0] lo_x_c, hi_x_c, lo_y_c, hi_y_c, hx_raw, hy_raw;

  always_comb begin
    lo_x_c = (px_q > POS_W'(rad_q)) ? ((BW'(px_q) - BW'(rad_q)) >> FRAC_BITS) : '0;
    lo_y_c = (py_q > POS_W'(rad_q)) ? ((BW'(py_q) - BW'(rad_q)) >> FRAC_BITS) : '0;
    hx_raw = (BW'(px_q) + BW'(rad_q)) >> FRAC_BITS;
    hy_raw = (BW'(py_q) + BW'(rad_q)) >> FRAC_BITS;
    hi_x_c = (hx_raw >= BW'(nx)) ? BW'(nx) - BW'(1) : hx_raw;
    hi_y_c = (hy_raw >= BW'(ny)) ? BW'(ny) - BW'(1) : hy_raw;
  end

  // Scanner
  logic [CXW-1:0] cx;
  logic [CYW-1:0] cy;
  logic [AW-1:0]  row_base;
  logic           scan_last;
  logic           box_empty;

  assign scan_last = (BW'(cx) == hi_x) && (BW'(cy) == hi_y);
  assign box_empty = (lo_x > hi_x) || (lo_y > hi_y);

  // Distance pipeline
  logic                  p1_v, p2_v;
  logic [AW-1:0]         p1_idx, p2_idx;
  logic signed [DW-1:0]  p1_dx, p1_dy, dx_c, dy_c;
  logic [SQW-1:0]        sq_x, sq_y;
  logic signed [SQW-1:0] sqx_c, sqy_c;
  logic                  hit;

  assign dx_c  = $signed(DW'(px_q)) - $signed((DW'(cx) << FRAC_BITS) | HALF);
  assign dy_c  = $signed(DW'(py_q)) - $signed((DW'(cy) << FRAC_BITS) | HALF);
  assign sqx_c = p1_dx * p1_dx;
  assign sqy_c = p1_dy * p1_dy;
  assign hit   = ((SQW + 1)'(sq_x) + (SQW + 1)'(sq_y)) < (SQW + 1)'(r2);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= (state == ST_SCAN);
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= row_base + AW'(cx);
    p1_dx  <= dx_c;
    p1_dy  <= dy_c;
    p2_idx <= p1_idx;
    sq_x   <= SQW'(sqx_c);
    sq_y   <= SQW'(sqy_c);
  end

  // Counter RAM: read in stage one, write back in stage two
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_q;
  logic [AW-1:0]          clr_addr;
  logic                   mem_we;
  logic [AW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      mem_we  = p2_v && hit && (kind_q == KIND_ADD) && (rd_q != CMAX);
      wr_addr = p2_idx;
      wr_data = rd_q + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q <= mem[p1_idx];
  end

  // Accumulators and serial divider
  logic [HW-1:0]   hits;
  logic [SW-1:0]   sum;
  logic [NW-1:0]   dvd;
  logic [RW-1:0]   rem, rem_sh;
  logic [CNTW-1:0] div_cnt;
  logic            div_ge;

  assign rem_sh = {rem[RW-2:0], dvd[NW-1]};
  assign div_ge = rem_sh >= RW'(hits);

  // Result register
  logic      out_valid;
  disc_out_t out_data, res_c;
  logic [QW-1:0] q_ext;

  assign q_ext = QW'(dvd);
  always_comb begin
    res_c.mean_density = (q_ext > QW'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(q_ext);
    res_c.cells_hit    = (32'(hits) > 32'(HIT_MAX)) ? HIT_MAX : HIT_W'(hits);
    res_c.empty_disc   = (hits == '0);
  end

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Result register: load from the done step, clear on hand-off
      if ((state == ST_DONE) && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready)                     out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == DEPTH - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_ch.valid) state <= ST_BOX;
        end
        ST_BOX:  state <= ST_BASE;
        ST_BASE: state <= box_empty ? ST_DRAIN : ST_SCAN;
        ST_SCAN: begin
          if (scan_last) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!p1_v && !p2_v) begin
            state <= ((kind_q == KIND_SAMPLE) && (hits != '0)) ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_cnt == CNTW'(1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ch.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        kind_q <= in_ch.data.kind;
        px_q   <= in_ch.data.pos_x;
        py_q   <= in_ch.data.pos_y;
        rad_q  <= in_ch.data.disc_radius;
        hits   <= '0;
        sum    <= '0;
      end
      ST_BOX: begin
        lo_x <= lo_x_c;
        hi_x <= hi_x_c;
        lo_y <= lo_y_c;
        hi_y <= hi_y_c;
        r2   <= R2W'(rad_q) * R2W'(rad_q);
      end
      ST_BASE: begin
        cx       <= CXW'(lo_x);
        cy       <= CYW'(lo_y);
        row_base <= AW'(lo_y * BW'(nx));
      end
      ST_SCAN: begin
        if (BW'(cx) == hi_x) begin
          cx       <= CXW'(lo_x);
          cy       <= cy + CYW'(1);
          row_base <= row_base + AW'(nx);
        end else begin
          cx <= cx + CXW'(1);
        end
      end
      ST_DRAIN: begin
        dvd     <= ((kind_q == KIND_SAMPLE) && (hits != '0)) ?
                   {sum, {FRAC_BITS{1'b0}}} : '0;
        rem     <= '0;
        div_cnt <= CNTW'(NW);
      end
      ST_DIV: begin
        rem     <= div_ge ? rem_sh - RW'(hits) : rem_sh;
        dvd     <= {dvd[NW-2:0], div_ge};
        div_cnt <= div_cnt - CNTW'(1);
      end
      ST_DONE: begin
        if (!out_valid || out_ch.ready) out_data <= res_c;
      end
      default: ;
    endcase
    // Accumulate covered cells as they leave the pipeline
    if (p2_v && hit) begin
      hits <= hits + HW'(1);
      if (kind_q == KIND_SAMPLE) sum <= sum + SW'(rd_q);
    end
  end

`ifndef SYNTHESIS
  // A new item only enters once the cell pipeline has drained
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (!p1_v && !p2_v))
    else $error("item accepted with cells still in flight");

  // Sample items never modify the counter grid
  a_sample_no_write: assert property (@(posedge clk) disable iff (rst)
    (p2_v && (kind_q == KIND_SAMPLE)) |-> !mem_we)
    else $error("grid written during a sample item");

  // A result only appears after the sequencer finished an item
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done step");
`endif

endmodule

// ===== sim/testbench.sv =====
// Testbench for disc_density_grid: random and directed discs with grid size changes.
// A scoreboard class keeps a shadow grid and predicts every result.
// Depends on ddg_pkg, ddg_chan_if and the disc_density_grid RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ddg_pkg::*;

  localparam int GRID_X     = 64;
  localparam int GRID_Y     = 64;
  localparam int FRAC       = 8;
  localparam int CNT_MAX    = 65535;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  // Shadow grid and expected result queue
  class density_scoreboard;
    bit [15:0]  counts [GRID_X*GRID_Y];
    bit [6:0]   reg_x, reg_y;
    disc_out_t  pending_q [$];
    int         errors;

    function new();
      foreach (counts[i]) counts[i] = '0;
      reg_x = CELLS_RESET;
      reg_y = CELLS_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_CELLS_X) reg_x = val;
      else if (idx == REG_CELLS_Y) reg_y = val;
    endfunction

    function int used_size(bit [6:0] v, int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return int'(v);
    endfunction

    // Walk the clamped bounding box, update or sum the covered cells
    function void note_disc(disc_in_t d);
      int nx, ny, lx, hx, ly, hy;
      longint dx, dy, r2;
      longint unsigned sum, mean;
      int hits, idx;
      disc_out_t res;
      nx = used_size(reg_x, GRID_X);
      ny = used_size(reg_y, GRID_Y);
      lx = (d.pos_x > d.disc_radius) ? ((d.pos_x - d.disc_radius) >> FRAC) : 0;
      hx = (int'(d.pos_x) + int'(d.disc_radius)) >> FRAC;
      if (hx >= nx) hx = nx - 1;
      ly = (d.pos_y > d.disc_radius) ? ((d.pos_y - d.disc_radius) >> FRAC) : 0;
      hy = (int'(d.pos_y) + int'(d.disc_radius)) >> FRAC;
      if (hy >= ny) hy = ny - 1;
      r2 = longint'(d.disc_radius) * longint'(d.disc_radius);
      hits = 0;
      sum = 0;
      mean = 0;
      for (int cy = ly; cy <= hy; cy++) begin
        for (int cx = lx; cx <= hx; cx++) begin
          dx = longint'(d.pos_x) - (longint'(cx) * 256 + 128);
          dy = longint'(d.pos_y) - (longint'(cy) * 256 + 128);
          if (dx * dx + dy * dy < r2) begin
            idx = cx + cy * nx;
            if (idx < GRID_X * GRID_Y) begin
              hits++;
              if (d.kind == KIND_SAMPLE) sum += counts[idx];
              else if (counts[idx] < CNT_MAX) counts[idx] = counts[idx] + 16'd1;
            end
          end
        end
      end
      if (d.kind == KIND_SAMPLE && hits != 0) begin
        mean = (sum << FRAC) / hits;
        if (mean > MEAN_MAX) mean = MEAN_MAX;
      end
      res.mean_density = mean[MEAN_W-1:0];
      res.cells_hit    = (hits > HIT_MAX) ? HIT_MAX : hits[HIT_W-1:0];
      res.empty_disc   = (hits == 0);
      pending_q.push_back(res);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(disc_out_t got);
      disc_out_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, cells_hit", got.cells_hit, -1);
      end else begin
        want = pending_q.pop_front();
        if (got.mean_density !== want.mean_density)
          report_mismatch("mean_density", got.mean_density, want.mean_density);
        if (got.cells_hit !== want.cells_hit)
          report_mismatch("cells_hit", got.cells_hit, want.cells_hit);
        if (got.empty_disc !== want.empty_disc)
          report_mismatch("empty_disc", got.empty_disc, want.empty_disc);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  bit calm = 1'b0;
  int stall_cycles = 0;
  density_scoreboard sb = new();

  ddg_chan_if #(.T(disc_in_t))  disc_ch ();
  ddg_chan_if #(.T(disc_out_t)) res_ch ();

  disc_density_grid uut (
    .clk(clk), .rst(rst), .in_ch(disc_ch), .out_ch(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    disc_ch.valid = 1'b0;
    disc_ch.data  = '0;
    res_ch.ready  = 1'b0;
  end

  // Result side: random back-pressure, checks at the rising edge
  always @(negedge clk) res_ch.ready <= calm || ($urandom_range(99) >= 29);

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((disc_ch.valid && disc_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we || rst)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one disc until it is taken, idling at random before it
  task send_disc(disc_in_t d);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (!calm && $urandom_range(99) < 29) begin
        disc_ch.valid <= 1'b0;
        @(posedge clk);
      end else begin
        disc_ch.valid <= 1'b1;
        disc_ch.data  <= d;
        @(posedge clk);
        if (disc_ch.ready) begin
          sb.note_disc(d);
          taken = 1'b1;
        end
      end
    end
  endtask

  task send_fields(logic kind, int px, int py, int r);
    disc_in_t d;
    d.kind = kind;
    d.pos_x = POS_W'(px);
    d.pos_y = POS_W'(py);
    d.disc_radius = RAD_W'(r);
    send_disc(d);
  endtask

  task drain_results();
    @(negedge clk);
    disc_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Register write once the block is idle
  task set_grid(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    disc_in_t d;
    int nx, span;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero radius, full extents, exact boundary, add then sample
    send_fields(KIND_ADD, 0, 0, 0);
    send_fields(KIND_ADD, 16383, 16383, 4095);
    send_fields(KIND_SAMPLE, 16383, 16383, 4095);
    send_fields(KIND_ADD, 0, 0, 4095);
    send_fields(KIND_SAMPLE, 0, 16383, 4095);
    send_fields(KIND_ADD, 128, 128, 1);
    send_fields(KIND_SAMPLE, 128, 128, 1);
    send_fields(KIND_ADD, 256, 128, 128);
    send_fields(KIND_SAMPLE, 256, 256, 182);
    send_fields(KIND_SAMPLE, 8192, 8192, 2000);
    // Box outside a narrowed grid, zero and oversized sizes, ignored indexes
    set_grid(REG_CELLS_X, 7'd0);
    set_grid(REG_CELLS_Y, 7'd127);
    send_fields(KIND_SAMPLE, 10000, 300, 200);
    send_fields(KIND_ADD, 128, 9000, 600);
    set_grid(REG_UNUSED_A, 7'd5);
    set_grid(REG_UNUSED_B, 7'd9);
    send_fields(KIND_SAMPLE, 128, 9000, 600);

    // Repeated adds on the single cell of a 1x1 grid with no idling
    set_grid(REG_CELLS_X, 7'd1);
    set_grid(REG_CELLS_Y, 7'd1);
    calm = 1'b1;
    repeat (20) send_fields(KIND_ADD, 128, 128, 100);
    send_fields(KIND_SAMPLE, 128, 128, 100);
    calm = 1'b0;

    // Random discs through several grid sizes
    for (int i = 0; i < 550; i++) begin
      if (i % 80 == 0) begin
        case ($urandom_range(5))
          0: set_grid(REG_CELLS_X, 7'd1);
          1: set_grid(REG_CELLS_X, 7'd64);
          2: set_grid(REG_CELLS_X, 7'd127);
          default: set_grid(REG_CELLS_X, CFG_W'($urandom_range(127)));
        endcase
        case ($urandom_range(5))
          0: set_grid(REG_CELLS_Y, 7'd0);
          1: set_grid(REG_CELLS_Y, 7'd64);
          2: set_grid(REG_CELLS_Y, 7'd1);
          default: set_grid(REG_CELLS_Y, CFG_W'($urandom_range(127)));
        endcase
      end
      if (i == 200) drain_results();
      calm = (i >= 300 && i < 380);
      nx = sb.used_size(sb.reg_x, GRID_X);
      span = sb.used_size(sb.reg_y, GRID_Y);
      d.kind = 1'($urandom_range(1));
      if ($urandom_range(9) < 7) begin
        d.pos_x = POS_W'($urandom_range(nx * 256 + 255 > 16383 ? 16383 : nx * 256 + 255));
        d.pos_y = POS_W'($urandom_range(span * 256 + 255 > 16383 ? 16383 : span * 256 + 255));
      end else begin
        d.pos_x = POS_W'($urandom_range(16383));
        d.pos_y = POS_W'($urandom_range(16383));
      end
      d.disc_radius = ($urandom_range(9) < 2) ? RAD_W'($urandom_range(4095)) :
                                                RAD_W'($urandom_range(700));
      send_disc(d);
    end
    calm = 1'b0;

    drain_results();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
